@@ sv/zvd_pkg.sv @@
// Shared types and constants for the zero-velocity detector.
`default_nettype none
package zvd_pkg;

    localparam int MAG_W      = 16;
    localparam int SPREAD_W   = 30;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 30;
    localparam int CNT_W      = 8;
    localparam int WIN_REG_W  = 7;
    localparam int QUO_W      = 31;

    localparam logic [SPREAD_W-1:0] SPREAD_MAX = {SPREAD_W{1'b1}};
    localparam logic [CNT_W-1:0]    CNT_MAX    = {CNT_W{1'b1}};

    localparam logic [15:0]          GRAVITY_LEVEL_RST   = 16'd4096;
    localparam logic [15:0]          GRAVITY_TOL_RST     = 16'd200;
    localparam logic [15:0]          ROTATION_LIMIT_RST  = 16'd100;
    localparam logic [SPREAD_W-1:0]  ACCEL_SPREAD_RST    = 30'd400;
    localparam logic [SPREAD_W-1:0]  ROT_SPREAD_RST      = 30'd100;
    localparam logic [WIN_REG_W-1:0] WINDOW_LENGTH_RST   = 7'd32;
    localparam logic [CNT_W-1:0]     ENTRY_PERSIST_RST   = 8'd10;
    localparam logic [CNT_W-1:0]     EXIT_HYST_RST       = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY_LEVEL      = 4'd0,
        REG_GRAVITY_TOLERANCE  = 4'd1,
        REG_ROTATION_LIMIT     = 4'd2,
        REG_ACCEL_SPREAD_LIMIT = 4'd3,
        REG_ROT_SPREAD_LIMIT   = 4'd4,
        REG_WINDOW_LENGTH      = 4'd5,
        REG_ENTRY_PERSISTENCE  = 4'd6,
        REG_EXIT_HYSTERESIS    = 4'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_MOVING     = 2'd0,
        MODE_CANDIDATE  = 2'd1,
        MODE_STATIONARY = 2'd2,
        MODE_LEAVING    = 2'd3
    } motion_mode_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SQUARE,
        SEQ_ROOT,
        SEQ_WRITE,
        SEQ_WALK,
        SEQ_PRODUCT,
        SEQ_DIVIDE,
        SEQ_DONE
    } seq_state_t;

    // handshake with an iterative arithmetic unit
    typedef struct packed {
        logic start;
    } unit_req_t;

endpackage
`default_nettype wire

@@ sv/zvd_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module zvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/zvd_sqrt.sv @@
// Bit-serial floor integer square root that works one radicand at a time; busy is high until the root is complete.
`default_nettype none
module zvd_sqrt #(
    parameter int IN_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire zvd_pkg::unit_req_t req,
    input  wire logic [IN_W-1:0]   radicand,
    output logic                   busy,
    output logic [IN_W/2:0]        root
);
    import zvd_pkg::*;

    localparam int STEPS = IN_W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [IN_W-1:0] v_reg, v_next;
    logic [IN_W-1:0] res_reg, res_next;
    logic [IN_W-1:0] bit_reg, bit_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IN_W-1:0] trial;

    always_comb begin
        trial    = res_reg + bit_reg;
        v_next   = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        if (req.start) begin
            v_next   = radicand;
            res_next = '0;
            bit_next = IN_W'(1) << (IN_W - 2);
            cnt_next = CW'(STEPS);
        end else if (cnt_reg != '0) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = res_reg[IN_W/2:0];

endmodule
`default_nettype wire

@@ sv/zvd_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module zvd_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 22,
    parameter int QW    = 31
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire zvd_pkg::unit_req_t req,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    output logic                    busy,
    output logic [QW-1:0]           quo
);
    import zvd_pkg::*;

    localparam int DSH_W = DEN_W + QW;
    localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int CW    = $clog2(QW + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QW-1:0]    quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             ge;

    assign ge = CMP_W'(rem_reg) >= CMP_W'(dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (req.start) begin
            cnt_reg <= CW'(QW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (req.start) begin
            rem_reg <= num;
            dsh_reg <= DSH_W'(den) << (QW - 1);
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            if (ge) begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            quo_reg <= {quo_reg[QW-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule
`default_nettype wire

@@ sv/zero_velocity_detector_core.sv @@
// Zero-velocity detector: IMU norms, windowed variance and stationary-state machine.
// One sample is worked at a time. An accepted sample passes through the squaring,
// root, write, window walk, product and divide steps into the output register,
// and the next sample can be taken in the cycle after that load. The square
// roots, the window walk through the two ring memories and the bit-serial
// variance divider are the long steps, and a window below three skips the walk,
// the product step and the divider. The next sample is taken as soon as the
// previous result sits in the output register, even while it waits to be transferred.
// The rings need no clearing after reset, so the block is ready at once.
// Configuration writes take effect immediately; the user must keep them to idle periods (not enforced).
`default_nettype none
module zero_velocity_detector_core #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_accel_z,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_rate_x,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_rate_y,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_rate_z,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_motion_mode,
    output logic [zvd_pkg::MAG_W-1:0]              m_accel_magnitude,
    output logic [zvd_pkg::MAG_W-1:0]              m_rotation_magnitude,
    output logic [zvd_pkg::SPREAD_W-1:0]           m_accel_spread,
    output logic [zvd_pkg::SPREAD_W-1:0]           m_rotation_spread,
    input  wire logic                              cfg_we,
    input  wire logic [zvd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [zvd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import zvd_pkg::*;

    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int W_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int SC_W   = W_W + 1;
    localparam int SB     = SAMPLE_BITS;
    localparam int SQ_W   = 2 * SB;
    localparam int NRM_W  = SB + 1;
    localparam int SUM_W  = MAG_W + W_W;
    localparam int PW_W   = 2 * MAG_W + W_W;
    localparam int NUM_W  = 2 * SUM_W;
    localparam int DEN_W  = 2 * W_W;
    localparam int WX_W   = (W_W > WIN_REG_W) ? W_W : WIN_REG_W;
    localparam int CMP_W  = ((NRM_W > MAG_W) ? NRM_W : MAG_W) + 1;

    // configuration
    logic [15:0]          grav_level_reg;
    logic [15:0]          grav_tol_reg;
    logic [15:0]          rot_limit_reg;
    logic [SPREAD_W-1:0]  acc_spread_lim_reg;
    logic [SPREAD_W-1:0]  rot_spread_lim_reg;
    logic [WIN_REG_W-1:0] window_reg;
    logic [CNT_W-1:0]     entry_persist_reg;
    logic [CNT_W-1:0]     exit_hyst_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_level_reg     <= GRAVITY_LEVEL_RST;
            grav_tol_reg       <= GRAVITY_TOL_RST;
            rot_limit_reg      <= ROTATION_LIMIT_RST;
            acc_spread_lim_reg <= ACCEL_SPREAD_RST;
            rot_spread_lim_reg <= ROT_SPREAD_RST;
            window_reg         <= WINDOW_LENGTH_RST;
            entry_persist_reg  <= ENTRY_PERSIST_RST;
            exit_hyst_reg      <= EXIT_HYST_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRAVITY_LEVEL:      grav_level_reg     <= cfg_wdata[15:0];
                REG_GRAVITY_TOLERANCE:  grav_tol_reg       <= cfg_wdata[15:0];
                REG_ROTATION_LIMIT:     rot_limit_reg      <= cfg_wdata[15:0];
                REG_ACCEL_SPREAD_LIMIT: acc_spread_lim_reg <= cfg_wdata[SPREAD_W-1:0];
                REG_ROT_SPREAD_LIMIT:   rot_spread_lim_reg <= cfg_wdata[SPREAD_W-1:0];
                REG_WINDOW_LENGTH:      window_reg         <= cfg_wdata[WIN_REG_W-1:0];
                REG_ENTRY_PERSISTENCE:  entry_persist_reg  <= cfg_wdata[CNT_W-1:0];
                REG_EXIT_HYSTERESIS:    exit_hyst_reg      <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    seq_state_t      state_reg, state_next;
    logic [SC_W-1:0] sub_cnt_reg, sub_cnt_next;
    logic            root_start, ram_we, rd_en, div_start, out_load;
    logic            root_busy, div_busy;
    logic [W_W-1:0]  w_reg, w_now, win, fill_reg, fill_inc;
    logic [SC_W-1:0] w_ext;

    assign w_ext = SC_W'(w_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:    if (s_valid) state_next = SEQ_SQUARE;
            SEQ_SQUARE:  if (sub_cnt_reg == SC_W'(7)) state_next = SEQ_ROOT;
            SEQ_ROOT:    if (!root_busy && !busy_g) state_next = SEQ_WRITE;
            SEQ_WRITE:   state_next = (w_now < W_W'(3)) ? SEQ_DONE : SEQ_WALK;
            SEQ_WALK:    if (sub_cnt_reg == w_ext + SC_W'(3)) state_next = SEQ_PRODUCT;
            SEQ_PRODUCT: if (sub_cnt_reg == SC_W'(2)) state_next = SEQ_DIVIDE;
            SEQ_DIVIDE:  if (!div_busy && !busy_dg) state_next = SEQ_DONE;
            SEQ_DONE:    if (out_load) state_next = SEQ_IDLE;
            default:     state_next = SEQ_IDLE;
        endcase
        sub_cnt_next = (state_next != state_reg) ? '0 : sub_cnt_reg + SC_W'(1);
    end

    always_comb begin
        s_ready    = (state_reg == SEQ_IDLE);
        root_start = (state_reg == SEQ_SQUARE) && (sub_cnt_reg == SC_W'(7));
        ram_we     = (state_reg == SEQ_WRITE);
        rd_en      = (state_reg == SEQ_WALK) && (sub_cnt_reg < w_ext);
        div_start  = (state_reg == SEQ_PRODUCT) && (sub_cnt_reg == SC_W'(2));
        out_load   = (state_reg == SEQ_DONE) && (!m_valid || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            sub_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            sub_cnt_reg <= sub_cnt_next;
        end
    end

    // sample capture and sums of squares, one square per cycle
    logic [SB-1:0]   samp_reg [6];
    logic [SB-1:0]   cur, mag;
    logic [SQ_W-1:0] prod_reg, acc_a_reg, acc_g_reg;
    logic [2:0]      sel;

    assign sel = sub_cnt_reg[2:0];
    always_comb begin
        cur = (sel < 3'd6) ? samp_reg[sel] : '0;
        mag = cur[SB-1] ? (~cur + SB'(1)) : cur;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            samp_reg[0] <= s_accel_x;
            samp_reg[1] <= s_accel_y;
            samp_reg[2] <= s_accel_z;
            samp_reg[3] <= s_rate_x;
            samp_reg[4] <= s_rate_y;
            samp_reg[5] <= s_rate_z;
            acc_a_reg   <= '0;
            acc_g_reg   <= '0;
        end else if (state_reg == SEQ_SQUARE) begin
            if (sel >= 3'd1 && sel <= 3'd3) begin
                acc_a_reg <= acc_a_reg + prod_reg;
            end else if (sel >= 3'd4 && sel <= 3'd6) begin
                acc_g_reg <= acc_g_reg + prod_reg;
            end
        end
        prod_reg <= mag * mag;
    end

    logic [NRM_W-1:0] root_a, root_g;
    logic             busy_g;
    unit_req_t        root_req, div_req;

    assign root_req.start = root_start;
    assign div_req.start  = div_start;

    zvd_sqrt #(.IN_W(SQ_W)) u_sqrt_accel (
        .aclk(aclk), .aresetn(aresetn), .req(root_req), .radicand(acc_a_reg),
        .busy(root_busy), .root(root_a)
    );

    zvd_sqrt #(.IN_W(SQ_W)) u_sqrt_rate (
        .aclk(aclk), .aresetn(aresetn), .req(root_req), .radicand(acc_g_reg),
        .busy(busy_g), .root(root_g)
    );

    // ring position and fill
    logic [AW-1:0]   wp_reg, rd_ptr_reg;
    logic [WX_W-1:0] win_ext;

    always_comb begin
        win_ext = WX_W'(window_reg);
        if (win_ext == '0) begin
            win = W_W'(1);
        end else if (win_ext > WX_W'(WINDOW_DEPTH)) begin
            win = W_W'(WINDOW_DEPTH);
        end else begin
            win = W_W'(win_ext);
        end
        fill_inc = (fill_reg < win) ? fill_reg + W_W'(1) : fill_reg;
        w_now    = (fill_inc < win) ? fill_inc : win;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (ram_we) begin
            wp_reg   <= (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            fill_reg <= fill_inc;
        end
        if (ram_we) begin
            w_reg      <= w_now;
            rd_ptr_reg <= wp_reg;
        end else if (rd_en) begin
            rd_ptr_reg <= (rd_ptr_reg == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_reg - AW'(1);
        end
    end

    logic [MAG_W-1:0] rdata_a, rdata_g;

    zvd_ram #(.WIDTH(MAG_W), .DEPTH(WINDOW_DEPTH)) u_ring_accel (
        .aclk(aclk), .we(ram_we), .waddr(wp_reg), .wdata(MAG_W'(root_a)),
        .re(rd_en), .raddr(rd_ptr_reg), .rdata(rdata_a)
    );

    zvd_ram #(.WIDTH(MAG_W), .DEPTH(WINDOW_DEPTH)) u_ring_rate (
        .aclk(aclk), .we(ram_we), .waddr(wp_reg), .wdata(MAG_W'(root_g)),
        .re(rd_en), .raddr(rd_ptr_reg), .rdata(rdata_g)
    );

    // window walk: read, square, scale by w, accumulate
    logic               rv_reg, v1_reg, v2_reg;
    logic [MAG_W-1:0]   d1_a_reg, d1_g_reg, d2_a_reg, d2_g_reg;
    logic [2*MAG_W-1:0] sq1_a_reg, sq1_g_reg;
    logic [PW_W-1:0]    pw_a_reg, pw_g_reg;
    logic [SUM_W-1:0]   sum_a_reg, sum_g_reg;
    logic [NUM_W-1:0]   wsq_a_reg, wsq_g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            rv_reg <= rd_en;
            v1_reg <= rv_reg;
            v2_reg <= v1_reg;
        end
        d1_a_reg  <= rdata_a;
        d1_g_reg  <= rdata_g;
        sq1_a_reg <= rdata_a * rdata_a;
        sq1_g_reg <= rdata_g * rdata_g;
        d2_a_reg  <= d1_a_reg;
        d2_g_reg  <= d1_g_reg;
        pw_a_reg  <= PW_W'(sq1_a_reg) * PW_W'(w_reg);
        pw_g_reg  <= PW_W'(sq1_g_reg) * PW_W'(w_reg);
        if (ram_we) begin
            sum_a_reg <= '0;
            sum_g_reg <= '0;
            wsq_a_reg <= '0;
            wsq_g_reg <= '0;
        end else if (v2_reg) begin
            sum_a_reg <= sum_a_reg + SUM_W'(d2_a_reg);
            sum_g_reg <= sum_g_reg + SUM_W'(d2_g_reg);
            wsq_a_reg <= wsq_a_reg + NUM_W'(pw_a_reg);
            wsq_g_reg <= wsq_g_reg + NUM_W'(pw_g_reg);
        end
    end

    // numerator and denominator of the variance
    logic [NUM_W-1:0] ssq_a_reg, ssq_g_reg, num_a_reg, num_g_reg;
    logic [DEN_W-1:0] den_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == SEQ_PRODUCT && sub_cnt_reg == SC_W'(0)) begin
            ssq_a_reg <= NUM_W'(sum_a_reg) * NUM_W'(sum_a_reg);
            ssq_g_reg <= NUM_W'(sum_g_reg) * NUM_W'(sum_g_reg);
            den_reg   <= DEN_W'(w_reg) * DEN_W'(w_reg);
        end
        if (state_reg == SEQ_PRODUCT && sub_cnt_reg == SC_W'(1)) begin
            num_a_reg <= wsq_a_reg - ssq_a_reg;
            num_g_reg <= wsq_g_reg - ssq_g_reg;
        end
    end

    logic [QUO_W-1:0] quo_a, quo_g;
    logic             busy_dg;

    zvd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QUO_W)) u_div_accel (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .num(num_a_reg),
        .den(den_reg), .busy(div_busy), .quo(quo_a)
    );

    zvd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QUO_W)) u_div_rate (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .num(num_g_reg),
        .den(den_reg), .busy(busy_dg), .quo(quo_g)
    );

    // candidate test and motion state
    logic [SPREAD_W-1:0] spread_a, spread_g;
    logic [CMP_W-1:0]    a_ext, g_ext, lvl_ext, diff, tol_ext, rlim_ext;
    logic                cand, severe;
    motion_mode_t        mode_reg, mode_next;
    logic [CNT_W-1:0]    entry_reg, entry_next, exit_reg, exit_next;
    logic [CNT_W-1:0]    entry_inc, exit_inc;

    always_comb begin
        if (w_reg < W_W'(3)) begin
            spread_a = '0;
            spread_g = '0;
        end else begin
            spread_a = (quo_a > QUO_W'(SPREAD_MAX)) ? SPREAD_MAX : quo_a[SPREAD_W-1:0];
            spread_g = (quo_g > QUO_W'(SPREAD_MAX)) ? SPREAD_MAX : quo_g[SPREAD_W-1:0];
        end
        a_ext    = CMP_W'(root_a);
        g_ext    = CMP_W'(root_g);
        lvl_ext  = CMP_W'(grav_level_reg);
        tol_ext  = CMP_W'(grav_tol_reg);
        rlim_ext = CMP_W'(rot_limit_reg);
        diff     = (a_ext >= lvl_ext) ? a_ext - lvl_ext : lvl_ext - a_ext;
        cand     = (diff <= tol_ext) && (g_ext <= rlim_ext)
                   && (spread_a <= acc_spread_lim_reg) && (spread_g <= rot_spread_lim_reg);
        severe   = (diff > (tol_ext << 1)) || (g_ext > (rlim_ext << 1));
        entry_inc = (entry_reg < CNT_MAX) ? entry_reg + CNT_W'(1) : entry_reg;
        exit_inc  = (exit_reg < CNT_MAX) ? exit_reg + CNT_W'(1) : exit_reg;
    end

    always_comb begin
        mode_next  = mode_reg;
        entry_next = entry_reg;
        exit_next  = exit_reg;
        unique case (mode_reg)
            MODE_MOVING: begin
                if (cand) begin
                    mode_next  = MODE_CANDIDATE;
                    entry_next = CNT_W'(1);
                end else begin
                    entry_next = '0;
                end
            end
            MODE_CANDIDATE: begin
                if (cand) begin
                    entry_next = entry_inc;
                    if (entry_inc >= entry_persist_reg) begin
                        mode_next = MODE_STATIONARY;
                    end
                end else begin
                    mode_next  = MODE_MOVING;
                    entry_next = '0;
                end
            end
            MODE_STATIONARY: begin
                if (cand) begin
                    exit_next = '0;
                end else if (severe) begin
                    mode_next  = MODE_MOVING;
                    entry_next = '0;
                    exit_next  = '0;
                end else begin
                    mode_next = MODE_LEAVING;
                    exit_next = CNT_W'(1);
                end
            end
            MODE_LEAVING: begin
                if (cand) begin
                    mode_next = MODE_STATIONARY;
                    exit_next = '0;
                end else if (exit_inc >= exit_hyst_reg) begin
                    mode_next  = MODE_MOVING;
                    entry_next = '0;
                    exit_next  = '0;
                end else begin
                    exit_next = exit_inc;
                end
            end
            default: mode_next = MODE_MOVING;
        endcase
    end

    // result register: hold until transferred
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_MOVING;
            entry_reg   <= '0;
            exit_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                mode_reg    <= mode_next;
                entry_reg   <= entry_next;
                exit_reg    <= exit_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            m_motion_mode        <= mode_next;
            m_accel_magnitude    <= MAG_W'(root_a);
            m_rotation_magnitude <= MAG_W'(root_g);
            m_accel_spread       <= spread_a;
            m_rotation_spread    <= spread_g;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ verif/tb_zero_velocity_detector_core.sv @@
// Self-checking testbench for the zero-velocity detector core.
`timescale 1ns / 1ps
module tb_zero_velocity_detector_core;
    import zvd_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] a_mag;
        logic [15:0] r_mag;
        logic [29:0] a_spr;
        logic [29:0] r_spr;
    } zvd_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_accel_x = '0, s_accel_y = '0, s_accel_z = '0;
    logic signed [15:0] s_rate_x = '0, s_rate_y = '0, s_rate_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_motion_mode;
    logic [15:0] m_accel_magnitude, m_rotation_magnitude;
    logic [29:0] m_accel_spread, m_rotation_spread;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    zero_velocity_detector_core dut (.*);

    // predictor state
    logic [29:0] regs_m [8];
    logic [15:0] accel_hist [DEPTH];
    logic [15:0] rot_hist [DEPTH];
    int unsigned wpos, filled, entry_cnt, exit_cnt;
    motion_mode_t mode_m;

    zvd_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stall_rx = 0;
    bit no_idle = 0;
    int rx_idle_pct = 20;
    int tx_idle_pct = 20;

    initial forever #10 aclk = ~aclk;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned norm_of(logic signed [15:0] x, logic signed [15:0] y,
                                                logic signed [15:0] z);
        longint unsigned a, b, c;
        a = (x < 0) ? -longint'(x) : longint'(x);
        b = (y < 0) ? -longint'(y) : longint'(y);
        c = (z < 0) ? -longint'(z) : longint'(z);
        return isqrt(a * a + b * b + c * c);
    endfunction

    function automatic longint unsigned window_spread(bit rot, int unsigned w);
        longint unsigned s = 0, sq = 0, v, q;
        int unsigned idx;
        if (w < 3) return 0;
        for (int unsigned i = 0; i < w; i++) begin
            idx = (wpos + 2 * DEPTH - 1 - i) % DEPTH;
            v = rot ? rot_hist[idx] : accel_hist[idx];
            s += v;
            sq += v * v;
        end
        q = (w * sq - s * s) / (w * w);
        return (q > SPREAD_MAX) ? SPREAD_MAX : q;
    endfunction

    function automatic void reset_predictor();
        regs_m[REG_GRAVITY_LEVEL] = GRAVITY_LEVEL_RST;
        regs_m[REG_GRAVITY_TOLERANCE] = GRAVITY_TOL_RST;
        regs_m[REG_ROTATION_LIMIT] = ROTATION_LIMIT_RST;
        regs_m[REG_ACCEL_SPREAD_LIMIT] = ACCEL_SPREAD_RST;
        regs_m[REG_ROT_SPREAD_LIMIT] = ROT_SPREAD_RST;
        regs_m[REG_WINDOW_LENGTH] = WINDOW_LENGTH_RST;
        regs_m[REG_ENTRY_PERSISTENCE] = ENTRY_PERSIST_RST;
        regs_m[REG_EXIT_HYSTERESIS] = EXIT_HYST_RST;
        for (int i = 0; i < DEPTH; i++) begin
            accel_hist[i] = 0;
            rot_hist[i] = 0;
        end
        wpos = 0; filled = 0; entry_cnt = 0; exit_cnt = 0;
        mode_m = MODE_MOVING;
    endfunction

    function automatic zvd_result_t detect_motion(logic signed [15:0] s [6]);
        zvd_result_t r;
        longint unsigned an, gn, av, gv, lvl, dif, tol, rl;
        int unsigned win, w;
        bit cand;
        an = norm_of(s[0], s[1], s[2]);
        gn = norm_of(s[3], s[4], s[5]);
        win = regs_m[REG_WINDOW_LENGTH];
        if (win < 1) win = 1;
        if (win > DEPTH) win = DEPTH;
        accel_hist[wpos] = an[15:0];
        rot_hist[wpos] = gn[15:0];
        wpos = (wpos + 1) % DEPTH;
        if (filled < win) filled++;
        w = (filled < win) ? filled : win;
        av = window_spread(0, w);
        gv = window_spread(1, w);
        lvl = regs_m[REG_GRAVITY_LEVEL];
        tol = regs_m[REG_GRAVITY_TOLERANCE];
        rl = regs_m[REG_ROTATION_LIMIT];
        dif = (an >= lvl) ? an - lvl : lvl - an;
        cand = dif <= tol && gn <= rl && av <= regs_m[REG_ACCEL_SPREAD_LIMIT]
               && gv <= regs_m[REG_ROT_SPREAD_LIMIT];
        case (mode_m)
            MODE_MOVING: begin
                if (cand) begin
                    mode_m = MODE_CANDIDATE;
                    entry_cnt = 1;
                end else begin
                    entry_cnt = 0;
                end
            end
            MODE_CANDIDATE: begin
                if (cand) begin
                    if (entry_cnt < 255) entry_cnt++;
                    if (entry_cnt >= regs_m[REG_ENTRY_PERSISTENCE]) mode_m = MODE_STATIONARY;
                end else begin
                    mode_m = MODE_MOVING;
                    entry_cnt = 0;
                end
            end
            MODE_STATIONARY: begin
                if (cand) begin
                    exit_cnt = 0;
                end else if (dif > 2 * tol || gn > 2 * rl) begin
                    mode_m = MODE_MOVING;
                    entry_cnt = 0;
                    exit_cnt = 0;
                end else begin
                    mode_m = MODE_LEAVING;
                    exit_cnt = 1;
                end
            end
            default: begin
                if (cand) begin
                    mode_m = MODE_STATIONARY;
                    exit_cnt = 0;
                end else begin
                    if (exit_cnt < 255) exit_cnt++;
                    if (exit_cnt >= regs_m[REG_EXIT_HYSTERESIS]) begin
                        mode_m = MODE_MOVING;
                        entry_cnt = 0;
                        exit_cnt = 0;
                    end
                end
            end
        endcase
        r.mode = mode_m;
        r.a_mag = an[15:0];
        r.r_mag = gn[15:0];
        r.a_spr = av[29:0];
        r.r_spr = gv[29:0];
        return r;
    endfunction

    // result checker and receiver idling
    always @(posedge aclk) begin
        zvd_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result mode=%0d", $time, m_motion_mode);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_motion_mode !== e.mode || m_accel_magnitude !== e.a_mag ||
                    m_rotation_magnitude !== e.r_mag || m_accel_spread !== e.a_spr ||
                    m_rotation_spread !== e.r_spr) begin
                    $display("%0t mismatch exp mode=%0d am=%0d rm=%0d as=%0d rs=%0d",
                             $time, e.mode, e.a_mag, e.r_mag, e.a_spr, e.r_spr);
                    $display("%0t          got mode=%0d am=%0d rm=%0d as=%0d rs=%0d",
                             $time, m_motion_mode, m_accel_magnitude, m_rotation_magnitude,
                             m_accel_spread, m_rotation_spread);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk)
        m_ready <= !stall_rx && (no_idle || $urandom_range(99) >= rx_idle_pct);

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[zero_velocity_detector_core] ERROR");
            $finish;
        end
    end

    // start on a later falling edge than the previous drop of valid, after random idling unless no_idle is set
    task automatic send_sample(logic signed [15:0] s [6]);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < tx_idle_pct) @(negedge aclk);
        s_valid <= 1'b1;
        s_accel_x <= s[0]; s_accel_y <= s[1]; s_accel_z <= s[2];
        s_rate_x <= s[3]; s_rate_y <= s[4]; s_rate_z <= s[5];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(detect_motion(s));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [29:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        regs_m[idx] = val;
        @(negedge aclk);
    endtask

    // sample near rest with small noise, or a random one
    task automatic send_still(int noise, int level);
        logic signed [15:0] s [6];
        s[0] = 16'($urandom_range(2 * noise) - noise);
        s[1] = 16'($urandom_range(2 * noise) - noise);
        s[2] = 16'(level + $urandom_range(2 * noise) - noise);
        for (int i = 3; i < 6; i++) s[i] = 16'($urandom_range(2 * noise) - noise);
        send_sample(s);
    endtask

    task automatic send_random();
        logic signed [15:0] s [6];
        for (int i = 0; i < 6; i++) s[i] = 16'($urandom);
        send_sample(s);
    endtask

    task automatic test_extremes();
        logic signed [15:0] s [6];
        logic signed [15:0] vals [5] = '{16'sh8000, 16'sh7fff, 0, -1, 1};
        foreach (vals[k]) begin
            for (int i = 0; i < 6; i++) s[i] = vals[(k + i) % 5];
            send_sample(s);
        end
        for (int i = 0; i < 6; i++) s[i] = 16'sh8000;
        send_sample(s);
        for (int i = 0; i < 6; i++) s[i] = 16'sh7fff;
        send_sample(s);
        drain();
    endtask

    // near-rest samples with gentle and severe disturbances, entry persistence and exit hysteresis set to 3
    task automatic test_mode_walk();
        logic signed [15:0] s [6];
        write_reg(REG_ENTRY_PERSISTENCE, 3);
        write_reg(REG_EXIT_HYSTERESIS, 3);
        repeat (6) send_still(2, 4096);
        s = '{0, 0, 4096 + 300, 0, 0, 0};
        send_sample(s);
        repeat (2) send_still(1, 4096);
        send_sample(s);
        send_sample(s);
        send_sample(s);
        repeat (6) send_still(1, 4096);
        s = '{0, 0, -16000, 5000, 0, 0};
        send_sample(s);
        drain();
    endtask

    task automatic test_zero_limits();
        write_reg(REG_WINDOW_LENGTH, 0);
        write_reg(REG_ENTRY_PERSISTENCE, 0);
        write_reg(REG_EXIT_HYSTERESIS, 0);
        repeat (4) send_still(2, 4096);
        repeat (2) send_random();
        repeat (3) send_still(2, 4096);
        drain();
        write_reg(REG_WINDOW_LENGTH, 7'h7f);
        write_reg(REG_ACCEL_SPREAD_LIMIT, 30'h3fffffff);
        write_reg(REG_ROT_SPREAD_LIMIT, 30'h3fffffff);
        write_reg(REG_GRAVITY_TOLERANCE, 16'hffff);
        write_reg(REG_ROTATION_LIMIT, 16'hffff);
        write_reg(REG_ENTRY_PERSISTENCE, 255);
        write_reg(REG_EXIT_HYSTERESIS, 255);
        repeat (80) send_random();
        drain();
        // shrink window below the fill level
        write_reg(REG_WINDOW_LENGTH, 2);
        repeat (5) send_random();
        drain();
    endtask

    task automatic test_back_pressure();
        stall_rx = 1;
        fork
            begin
                repeat (400) @(negedge aclk);
                stall_rx = 0;
            end
            repeat (12) send_random();
        join
        drain();
    endtask

    task automatic random_phase(int n);
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(9);
            if (mode < 6) send_still($urandom_range(1, 30), regs_m[REG_GRAVITY_LEVEL]);
            else if (mode < 8) send_still($urandom_range(50, 4000), $urandom_range(0, 8000));
            else send_random();
        end
        drain();
    endtask

    task automatic test_random();
        write_reg(REG_GRAVITY_LEVEL, 4096);
        write_reg(REG_GRAVITY_TOLERANCE, 200);
        write_reg(REG_ROTATION_LIMIT, 100);
        write_reg(REG_ACCEL_SPREAD_LIMIT, 400);
        write_reg(REG_ROT_SPREAD_LIMIT, 100);
        write_reg(REG_WINDOW_LENGTH, 8);
        write_reg(REG_ENTRY_PERSISTENCE, 5);
        write_reg(REG_EXIT_HYSTERESIS, 4);
        random_phase(400);
        no_idle = 1;
        write_reg(REG_WINDOW_LENGTH, 64);
        write_reg(REG_GRAVITY_LEVEL, 16384);
        write_reg(REG_ENTRY_PERSISTENCE, 1);
        write_reg(REG_EXIT_HYSTERESIS, 1);
        random_phase(300);
        no_idle = 0;
        write_reg(REG_GRAVITY_LEVEL, 0);
        write_reg(REG_GRAVITY_TOLERANCE, 0);
        write_reg(REG_ROTATION_LIMIT, 0);
        write_reg(REG_ACCEL_SPREAD_LIMIT, 0);
        write_reg(REG_ROT_SPREAD_LIMIT, 0);
        write_reg(REG_WINDOW_LENGTH, 3);
        random_phase(150);
        write_reg(REG_GRAVITY_LEVEL, 1000);
        write_reg(REG_GRAVITY_TOLERANCE, 60);
        write_reg(REG_ROTATION_LIMIT, 40);
        write_reg(REG_ACCEL_SPREAD_LIMIT, 300);
        write_reg(REG_ROT_SPREAD_LIMIT, 200);
        write_reg(REG_WINDOW_LENGTH, 16);
        write_reg(REG_ENTRY_PERSISTENCE, 7);
        write_reg(REG_EXIT_HYSTERESIS, 3);
        random_phase(350);
    endtask

    initial begin
        reset_predictor();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_mode_walk();
        test_zero_limits();
        test_back_pressure();
        test_random();
        if (errors == 0 && pending_results.size() == 0)
            $display("[zero_velocity_detector_core] OK");
        else
            $display("[zero_velocity_detector_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/zvd_pkg.sv
sv/zvd_ram.sv
sv/zvd_sqrt.sv
sv/zvd_div.sv
sv/zero_velocity_detector_core.sv
verif/tb_zero_velocity_detector_core.sv
